// ===== rtl/text_terminal_writer_core_macros.svh =====
// Assertion macros for the text terminal writer core
`ifndef TEXT_TERMINAL_WRITER_CORE_MACROS_SVH
`define TEXT_TERMINAL_WRITER_CORE_MACROS_SVH

`ifndef SYNTHESIS

`define TTW_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define TTW_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    `TTW_ASSERT(label, clk, rst_n, !(cond), msg)

`else

`define TTW_ASSERT(label, clk, rst_n, prop, msg)

`define TTW_ASSERT_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

// ===== rtl/ttw_pkg.sv =====
// Shared constants, types and helpers of the text terminal writer core
package ttw_pkg;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = COLUMNS * ROWS;

    localparam int OP_W   = 2;
    localparam int CHAR_W = 8;
    localparam int IDX_W  = 11;
    localparam int CELL_W = 16;
    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;
    localparam int ATTR_W = 8;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [ROW_W-1:0]  LAST_ROW   = ROW_W'(ROWS - 1);
    localparam logic [COL_W-1:0]  LAST_COL   = COL_W'(COLUMNS - 1);
    localparam logic [IDX_W-1:0]  LAST_CELL  = IDX_W'(CELLS - 1);
    localparam logic [IDX_W-1:0]  COPY_END   = IDX_W'(CELLS - COLUMNS);
    localparam logic [IDX_W-1:0]  ROW_STRIDE = IDX_W'(COLUMNS);
    localparam logic [IDX_W-1:0]  CELL_LIMIT = IDX_W'(CELLS);

    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_FORMFEED  = 8'h0C;
    localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
    localparam logic [CHAR_W-1:0] LAST_CONTROL = 8'd31;
    localparam logic [ATTR_W-1:0] RESET_COLOR  = 8'h07;

    typedef enum logic [OP_W-1:0] {
        OP_PUT   = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        CMD_PUT,
        CMD_BACK,
        CMD_NEWLINE,
        CMD_RETURN,
        CMD_HOME,
        CMD_NOP,
        CMD_READ,
        CMD_CLEAR
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t               kind;
        logic [CHAR_W-1:0]       char_code;
        logic [IDX_W-1:0]        cell_index;
    } cmd_t;

    typedef struct packed {
        logic init_busy;
    } back_status_t;

    function automatic logic [IDX_W-1:0] cell_pos(input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col);
        return IDX_W'(row) * ROW_STRIDE + IDX_W'(col);
    endfunction

endpackage

// ===== rtl/ttw_if.sv =====
// Channel interfaces of the text terminal writer core
interface ttw_in_if import ttw_pkg::*;;
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [CHAR_W-1:0] char_code;
    logic [IDX_W-1:0]  cell_index;

    modport source (output valid, operation, char_code, cell_index, input ready);
    modport sink   (input valid, operation, char_code, cell_index, output ready);
endinterface

interface ttw_out_if import ttw_pkg::*;;
    logic              valid;
    logic              ready;
    logic [CELL_W-1:0] cell_value;
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_column;
    logic [IDX_W-1:0]  cursor_position;

    modport source (output valid, cell_value, cursor_row, cursor_column, cursor_position,
                    input ready);
    modport sink   (input valid, cell_value, cursor_row, cursor_column, cursor_position,
                    output ready);
endinterface

interface ttw_cfg_if import ttw_pkg::*;;
    logic              valid;
    logic              ready;
    logic [ATTR_W-1:0] text_color;

    modport source (output valid, text_color, input ready);
    modport sink   (input valid, text_color, output ready);
endinterface

// ===== rtl/ttw_front.sv =====
// Front end: accept input transactions and classify them into commands
module ttw_front import ttw_pkg::*;
(
    ttw_in_if.sink      cmd,
    input  back_status_t status,
    output logic        push_valid,
    input  logic        push_ready,
    output cmd_t        push_cmd
);

    assign cmd.ready  = push_ready && !status.init_busy;
    assign push_valid = cmd.valid && !status.init_busy;

    always_comb
    begin
        push_cmd.char_code  = cmd.char_code;
        push_cmd.cell_index = cmd.cell_index;
        push_cmd.kind       = CMD_NOP;
        unique case (cmd.operation)
            OP_PUT:
            begin
                priority if (cmd.char_code == CH_NEWLINE)
                    push_cmd.kind = CMD_NEWLINE;
                else if (cmd.char_code == CH_BACKSPACE)
                    push_cmd.kind = CMD_BACK;
                else if (cmd.char_code == CH_RETURN)
                    push_cmd.kind = CMD_RETURN;
                else if (cmd.char_code == CH_FORMFEED)
                    push_cmd.kind = CMD_HOME;
                else if (cmd.char_code > LAST_CONTROL)
                    push_cmd.kind = CMD_PUT;
                else
                    push_cmd.kind = CMD_NOP;
            end
            OP_READ:
            begin
                push_cmd.kind = (cmd.cell_index < CELL_LIMIT) ? CMD_READ : CMD_NOP;
            end
            OP_CLEAR:
            begin
                push_cmd.kind = CMD_CLEAR;
            end
            OP_NONE:
            begin
                push_cmd.kind = CMD_NOP;
            end
        endcase
    end

endmodule

// ===== rtl/ttw_queue.sv =====
// Command queue between front end and back end
module ttw_queue import ttw_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  cmd_t push_cmd,
    output logic pop_valid,
    input  logic pop_ready,
    output cmd_t pop_cmd
);

    cmd_t              slot_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              push, pop;

    assign push_ready = count_reg != QCNT_W'(QDEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_cmd    = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

// ===== rtl/ttw_back.sv =====
// Back end: cursor, screen memory, scroll and fill sweeps, result register
`include "text_terminal_writer_core_macros.svh"

module ttw_back import ttw_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    ttw_cfg_if.sink      cfg,
    ttw_out_if.source    res,
    input  logic         pop_valid,
    output logic         pop_ready,
    input  cmd_t         pop_cmd,
    output back_status_t status
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_READ  = 4'b0010,
        S_SWEEP = 4'b0100,
        S_DRAIN = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ATTR_W-1:0] text_color_reg, text_color_next;
    logic [IDX_W-1:0]  cnt_reg, cnt_next;
    logic              copy_reg, copy_next;
    logic [ATTR_W-1:0] attr_reg, attr_next;
    logic              report_reg, report_next;
    logic              init_reg, init_next;

    logic              pend_reg;
    logic [IDX_W-1:0]  pend_addr_reg;
    logic              pend_blank_reg;

    logic [CELL_W-1:0] screen_mem [CELLS];
    logic [CELL_W-1:0] rdata_reg;

    logic              res_valid_reg;
    logic [CELL_W-1:0] res_value_reg;
    logic [ROW_W-1:0]  res_row_reg;
    logic [COL_W-1:0]  res_col_reg;
    logic [IDX_W-1:0]  res_pos_reg;

    logic              res_free, pop;
    logic              res_load;
    logic [CELL_W-1:0] res_value;
    logic              cmd_we;
    logic [IDX_W-1:0]  cmd_waddr;
    logic [CELL_W-1:0] cmd_wdata;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic              sweep_issue;
    logic              sweep_read;
    logic              start_sweep, start_copy;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic [CELL_W-1:0] mem_wdata;

    assign res_free  = !res_valid_reg || res.ready;
    assign pop_ready = (state_reg == S_IDLE) && res_free;
    assign pop       = pop_ready && pop_valid;

    assign cfg.ready        = 1'b1;
    assign text_color_next  = cfg.valid ? cfg.text_color : text_color_reg;
    assign status.init_busy = init_reg;

    assign sweep_read = copy_reg && (cnt_reg < COPY_END);

    always_comb
    begin
        state_next  = state_reg;
        row_next    = row_reg;
        col_next    = col_reg;
        cnt_next    = cnt_reg;
        copy_next   = copy_reg;
        attr_next   = attr_reg;
        report_next = report_reg;
        init_next   = init_reg;
        cmd_we      = 1'b0;
        cmd_waddr   = cell_pos(row_reg, col_reg);
        cmd_wdata   = {text_color_reg, pop_cmd.char_code};
        rd_en       = 1'b0;
        rd_addr     = pop_cmd.cell_index;
        res_load    = 1'b0;
        res_value   = '0;
        sweep_issue = 1'b0;
        start_sweep = 1'b0;
        start_copy  = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (pop)
                begin
                    unique case (pop_cmd.kind)
                        CMD_PUT:
                        begin
                            cmd_we = 1'b1;
                            if (col_reg == LAST_COL)
                            begin
                                col_next = '0;
                                if (row_reg == LAST_ROW)
                                begin
                                    start_sweep = 1'b1;
                                    start_copy  = 1'b1;
                                end
                                else
                                begin
                                    row_next = row_reg + 1'b1;
                                    res_load = 1'b1;
                                end
                            end
                            else
                            begin
                                col_next = col_reg + 1'b1;
                                res_load = 1'b1;
                            end
                        end
                        CMD_BACK:
                        begin
                            if (col_reg == '0)
                            begin
                                col_next = LAST_COL;
                                row_next = (row_reg == '0) ? LAST_ROW : row_reg - 1'b1;
                            end
                            else
                            begin
                                col_next = col_reg - 1'b1;
                            end
                            cmd_we    = 1'b1;
                            cmd_waddr = cell_pos(row_next, col_next);
                            cmd_wdata = {text_color_reg, CH_SPACE};
                            res_load  = 1'b1;
                        end
                        CMD_NEWLINE:
                        begin
                            col_next = '0;
                            if (row_reg == LAST_ROW)
                            begin
                                start_sweep = 1'b1;
                                start_copy  = 1'b1;
                            end
                            else
                            begin
                                row_next = row_reg + 1'b1;
                                res_load = 1'b1;
                            end
                        end
                        CMD_RETURN:
                        begin
                            col_next = '0;
                            res_load = 1'b1;
                        end
                        CMD_HOME:
                        begin
                            row_next = '0;
                            col_next = '0;
                            res_load = 1'b1;
                        end
                        CMD_NOP:
                        begin
                            res_load = 1'b1;
                        end
                        CMD_READ:
                        begin
                            rd_en      = 1'b1;
                            state_next = S_READ;
                        end
                        CMD_CLEAR:
                        begin
                            row_next    = '0;
                            col_next    = '0;
                            start_sweep = 1'b1;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                res_load   = 1'b1;
                res_value  = rdata_reg;
                state_next = S_IDLE;
            end
            S_SWEEP:
            begin
                sweep_issue = 1'b1;
                rd_en       = sweep_read;
                rd_addr     = cnt_reg + ROW_STRIDE;
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == LAST_CELL)
                    state_next = S_DRAIN;
            end
            S_DRAIN:
            begin
                res_load   = report_reg;
                init_next  = 1'b0;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (start_sweep)
        begin
            state_next  = S_SWEEP;
            cnt_next    = '0;
            copy_next   = start_copy;
            attr_next   = text_color_reg;
            report_next = 1'b1;
        end
    end

    assign mem_we    = pend_reg || cmd_we;
    assign mem_waddr = pend_reg ? pend_addr_reg : cmd_waddr;
    assign mem_wdata = pend_reg ? (pend_blank_reg ? {attr_reg, CH_SPACE} : rdata_reg)
                                : cmd_wdata;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            screen_mem[mem_waddr] <= mem_wdata;
        if (rd_en)
            rdata_reg <= screen_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_SWEEP;
            row_reg        <= '0;
            col_reg        <= '0;
            text_color_reg <= RESET_COLOR;
            cnt_reg        <= '0;
            copy_reg       <= 1'b0;
            attr_reg       <= RESET_COLOR;
            report_reg     <= 1'b0;
            init_reg       <= 1'b1;
            pend_reg       <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            row_reg        <= row_next;
            col_reg        <= col_next;
            text_color_reg <= text_color_next;
            cnt_reg        <= cnt_next;
            copy_reg       <= copy_next;
            attr_reg       <= attr_next;
            report_reg     <= report_next;
            init_reg       <= init_next;
            pend_reg       <= sweep_issue;
            if (res_load)
                res_valid_reg <= 1'b1;
            else if (res.ready)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_addr_reg  <= cnt_reg;
        pend_blank_reg <= !sweep_read;
        if (res_load)
        begin
            res_value_reg <= res_value;
            res_row_reg   <= row_next;
            res_col_reg   <= col_next;
            res_pos_reg   <= cell_pos(row_next, col_next);
        end
    end

    assign res.valid           = res_valid_reg;
    assign res.cell_value      = res_value_reg;
    assign res.cursor_row      = res_row_reg;
    assign res.cursor_column   = res_col_reg;
    assign res.cursor_position = res_pos_reg;

    `TTW_ASSERT(a_late_result_slot_empty, clk, rst_n,
        (res_load && state_reg != S_IDLE) |-> !res_valid_reg, "late result overwrites output")
    `TTW_ASSERT_NEVER(a_single_writer, clk, rst_n,
        pend_reg && cmd_we, "sweep write collides with command write")
    `TTW_ASSERT(a_cursor_range, clk, rst_n,
        (row_reg <= LAST_ROW) && (col_reg <= LAST_COL), "cursor outside screen")
    `TTW_ASSERT_NEVER(a_no_result_in_init, clk, rst_n,
        init_reg && res_load, "result during reset clearing pass")

endmodule

// ===== rtl/text_terminal_writer_core.sv =====
// Top level of the text terminal writer core
// Usage:
//   cmd carries one operation per transaction: put a byte, read a cell, or
//   clear the screen and home the cursor. res returns exactly one result per
//   transaction, in order: the cell read (zero for other operations) and the
//   cursor row, column and linear position after the operation. cfg writes
//   the attribute byte used for written and blanked cells; write it only
//   while no transaction is outstanding.
//   With an idle back end a command is registered in the queue first; puts
//   and control bytes then load the result register, a read passes the
//   read state first. The back end retires one put per cycle unless stalled.
//   A scroll (newline or a wrapping put on the bottom row) and a clear walk
//   the whole screen memory, one cell per cycle through its single write
//   port; the back end stays busy until the drain state after the sweep
//   loads the result.
//   After reset the screen memory is filled with spaces in attribute 0x07 in
//   the same way; cmd.ready stays low until that pass ends, cfg is taken.
//   When res is stalled the result stays in the output register, the back
//   end holds the next command, and the two-entry queue keeps accepting
//   until full, then drops cmd.ready.
module text_terminal_writer_core import ttw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    ttw_in_if.sink     cmd,
    ttw_cfg_if.sink    cfg,
    ttw_out_if.source  res
);

    logic         push_valid, push_ready;
    cmd_t         push_cmd;
    logic         pop_valid, pop_ready;
    cmd_t         pop_cmd;
    back_status_t status;

    ttw_front u_front
    (
        .cmd        (cmd),
        .status     (status),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    ttw_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    ttw_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .res        (res),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd),
        .status     (status)
    );

endmodule
